/* hdl/assert_macros.svh */
// Assertion helpers shared by the tokenizer modules.
// Each macro expects i_clk and i_rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold in the same cycle as trig
`define CHECK_SAME(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("tokenizer assertion failed");

// cond must hold in the cycle after trig
`define CHECK_NEXT(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("tokenizer assertion failed");

`endif

/* hdl/stb_pkg.sv */
package stb_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int KIND_BITS   = 6;
    localparam int NUM_SLOTS   = 4;

    // token kinds
    localparam logic [KIND_BITS-1:0] K_NUMBER   = 6'd0;
    localparam logic [KIND_BITS-1:0] K_STRING   = 6'd1;
    localparam logic [KIND_BITS-1:0] K_KEYWORD0 = 6'd2;
    localparam logic [KIND_BITS-1:0] K_IDENT    = 6'd22;
    localparam logic [KIND_BITS-1:0] K_EQ_EQ    = 6'd23;
    localparam logic [KIND_BITS-1:0] K_GE       = 6'd24;
    localparam logic [KIND_BITS-1:0] K_LE       = 6'd25;
    localparam logic [KIND_BITS-1:0] K_NE       = 6'd26;
    localparam logic [KIND_BITS-1:0] K_SYM0     = 6'd27;
    localparam logic [KIND_BITS-1:0] K_SLASH    = 6'd33;
    localparam logic [KIND_BITS-1:0] K_END      = 6'd45;
    localparam logic [KIND_BITS-1:0] K_UNKNOWN  = 6'd46;

    // keyword table, text right-justified in each entry
    localparam int KW_COUNT   = 20;
    localparam int KW_MAX_LEN = 11;
    localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
        "#define", "#include", "struct", "fn", "var", "const", "__interrupt",
        "__zeropage", "u8", "u16", "u32", "u64", "i8", "i16", "i32", "i64",
        "bool", "str", "true", "false"
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd7, 4'd8, 4'd6, 4'd2, 4'd3, 4'd5, 4'd11, 4'd10, 4'd2, 4'd3,
        4'd3, 4'd3, 4'd2, 4'd3, 4'd3, 4'd3, 4'd4, 4'd3, 4'd4, 4'd5
    };

    // single symbols in kind order from K_SYM0
    localparam int SYM_COUNT = 18;
    localparam logic [7:0] SYM_CHARS [SYM_COUNT] = '{
        ":", ",", ";", "+", "-", "*", "/", "(", ")", "{", "}", "[", "]",
        "=", ".", "<", ">", "!"
    };

    typedef struct packed {
        logic [7:0] source_byte;
        logic       final_byte;
        logic       flush_only;
    } t_in_item;

    typedef struct packed {
        logic [KIND_BITS-1:0]   token_kind;
        logic [OFFSET_BITS-1:0] text_start;
        logic [OFFSET_BITS-1:0] text_length;
        logic                   run_end;
    } t_out_item;

    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS-1:0] length;
    } t_token;

    // all tokens caused by one input item, in emission order
    typedef struct packed {
        logic   [NUM_SLOTS-1:0] valid;
        t_token [NUM_SLOTS-1:0] tok;
    } t_bundle;

    // character i of keyword k, counted from the first character
    function automatic logic [7:0] kw_char(int k, int i);
        logic [KW_MAX_LEN*8-1:0] t;
        int                      pos;
        t   = KW_TEXT[k];
        pos = int'(KW_LEN[k]) - 1 - i;
        if (pos >= 0) begin
            return t[pos*8 +: 8];
        end
        return 8'h00;
    endfunction

    function automatic logic [KIND_BITS-1:0] symbol_kind(logic [7:0] c);
        logic [KIND_BITS-1:0] kind;
        kind = K_UNKNOWN;
        for (int i = 0; i < SYM_COUNT; i++) begin
            if (SYM_CHARS[i] == c) begin
                kind = K_SYM0 + KIND_BITS'(i);
            end
        end
        return kind;
    endfunction

endpackage

/* hdl/stb_front.sv */
`include "assert_macros.svh"

module stb_front
    import stb_pkg::*;
#(
    parameter int KEYWORD_CHARS = 11
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    input  logic     i_full,
    output logic     o_push,
    output t_bundle  o_push_data
);

    localparam int CNT_W = $clog2(KEYWORD_CHARS + 2);
    localparam int IDX_W = $clog2(KEYWORD_CHARS);

    // lexer modes
    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_COMMENT = 4'd1;
    localparam logic [3:0] M_SLASH   = 4'd2;
    localparam logic [3:0] M_ZERO    = 4'd3;
    localparam logic [3:0] M_DEC     = 4'd4;
    localparam logic [3:0] M_HEX     = 4'd5;
    localparam logic [3:0] M_BIN     = 4'd6;
    localparam logic [3:0] M_STRING  = 4'd7;
    localparam logic [3:0] M_WORD    = 4'd8;
    localparam logic [3:0] M_OP      = 4'd9;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CH_EQ    = "=";
    localparam logic [7:0] CH_GT    = ">";
    localparam logic [7:0] CH_LT    = "<";
    localparam logic [7:0] CH_BANG  = "!";

    logic [3:0]             r_mode,  n_mode;
    logic [OFFSET_BITS-1:0] r_pos;
    logic [OFFSET_BITS-1:0] r_start, n_start;
    logic [7:0]             r_pend,  n_pend;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [7:0]             r_prefix [KEYWORD_CHARS];
    logic [7:0]             n_prefix [KEYWORD_CHARS];

    logic                   w_accept;
    logic [7:0]             w_c;
    logic [OFFSET_BITS-1:0] w_pos_n;
    logic                   w_close, w_start, w_pair;
    logic [KIND_BITS-1:0]   w_word_kind;

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_xdigit(logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic is_word(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == "_" || c == "#";
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == " " || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [OFFSET_BITS-1:0] sat_inc(logic [OFFSET_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [KIND_BITS-1:0] pair_kind(logic [7:0] c);
        logic [KIND_BITS-1:0] kind;
        case (c)
            CH_EQ:   kind = K_EQ_EQ;
            CH_GT:   kind = K_GE;
            CH_LT:   kind = K_LE;
            default: kind = K_NE;
        endcase
        return kind;
    endfunction

    function automatic logic closes(logic [3:0] mode);
        logic v;
        unique case (mode)
            M_SLASH, M_ZERO, M_DEC, M_HEX, M_BIN, M_STRING, M_WORD, M_OP: v = 1'b1;
            default: v = 1'b0;
        endcase
        return v;
    endfunction

    // token left by an open mode when the text ends before pos
    function automatic t_token close_tok(logic [3:0] mode, logic [OFFSET_BITS-1:0] st,
                                         logic [OFFSET_BITS-1:0] pos, logic [7:0] pend,
                                         logic [KIND_BITS-1:0] wk);
        t_token t;
        t.kind   = K_NUMBER;
        t.start  = st;
        t.length = pos - st;
        unique case (mode)
            M_SLASH: begin
                t.kind   = K_SLASH;
                t.length = OFFSET_BITS'(1);
            end
            M_STRING: begin
                t.kind   = K_STRING;
                t.start  = sat_inc(st);
                t.length = (pos > st) ? pos - st - 1'b1 : '0;
            end
            M_WORD: t.kind = wk;
            M_OP: begin
                t.kind   = symbol_kind(pend);
                t.length = OFFSET_BITS'(1);
            end
            default: t.kind = K_NUMBER;
        endcase
        return t;
    endfunction

    assign o_in_ready = !i_full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_c        = i_in_data.source_byte;
    assign w_pos_n    = i_in_data.flush_only ? r_pos : sat_inc(r_pos);

    // feed one byte: next mode, word buffer and which tokens close or start
    always_comb begin
        n_mode   = r_mode;
        n_start  = r_start;
        n_pend   = r_pend;
        n_count  = r_count;
        n_prefix = r_prefix;
        w_close  = 1'b0;
        w_start  = 1'b0;
        w_pair   = 1'b0;
        if (!i_in_data.flush_only) begin
            unique case (r_mode)
                M_COMMENT: begin
                    if (w_c == CH_LF) n_mode = M_IDLE;
                end
                M_SLASH: begin
                    if (w_c == CH_SLASH) n_mode = M_COMMENT;
                    else begin
                        w_close = 1'b1;
                        w_start = 1'b1;
                    end
                end
                M_ZERO: begin
                    if (w_c == "x") n_mode = M_HEX;
                    else if (w_c == "b") n_mode = M_BIN;
                    else if (is_digit(w_c)) n_mode = M_DEC;
                    else begin
                        w_close = 1'b1;
                        w_start = 1'b1;
                    end
                end
                M_DEC, M_HEX, M_BIN: begin
                    if (!((r_mode == M_DEC && is_digit(w_c)) ||
                          (r_mode == M_HEX && is_xdigit(w_c)) ||
                          (r_mode == M_BIN && (w_c == "0" || w_c == "1")))) begin
                        w_close = 1'b1;
                        w_start = 1'b1;
                    end
                end
                M_STRING: begin
                    if (w_c == CH_QUOTE) begin
                        w_close = 1'b1;
                        n_mode  = M_IDLE;
                    end
                end
                M_WORD: begin
                    if (is_word(w_c)) begin
                        if (r_count < CNT_W'(KEYWORD_CHARS)) begin
                            n_prefix[r_count[IDX_W-1:0]] = w_c;
                        end
                        if (r_count <= CNT_W'(KEYWORD_CHARS)) begin
                            n_count = r_count + 1'b1;
                        end
                    end else begin
                        w_close = 1'b1;
                        w_start = 1'b1;
                    end
                end
                M_OP: begin
                    if (w_c == CH_EQ) begin
                        w_pair = 1'b1;
                        n_mode = M_IDLE;
                    end else begin
                        w_close = 1'b1;
                        w_start = 1'b1;
                    end
                end
                default: w_start = 1'b1;
            endcase
        end
        // open the next token at this byte
        if (w_start) begin
            n_start = r_pos;
            n_mode  = M_IDLE;
            if (w_c == CH_SLASH) n_mode = M_SLASH;
            else if (is_digit(w_c)) n_mode = (w_c == "0") ? M_ZERO : M_DEC;
            else if (w_c == CH_QUOTE) n_mode = M_STRING;
            else if (is_word(w_c)) begin
                n_mode      = M_WORD;
                n_prefix[0] = w_c;
                n_count     = CNT_W'(1);
            end else if (w_c == CH_EQ || w_c == CH_GT || w_c == CH_LT || w_c == CH_BANG) begin
                n_mode = M_OP;
                n_pend = w_c;
            end
        end
    end

    // keyword match on the word buffer after this byte
    always_comb begin
        logic hit;
        w_word_kind = K_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            hit = (n_count == CNT_W'(KW_LEN[k]));
            for (int i = 0; i < KW_MAX_LEN; i++) begin
                if (i < int'(KW_LEN[k]) && n_prefix[i] != kw_char(k, i)) hit = 1'b0;
            end
            if (hit) w_word_kind = K_KEYWORD0 + KIND_BITS'(k);
        end
    end

    // build the bundle: feed close or pair, immediate symbol, final close, END
    always_comb begin
        o_push_data = '0;
        if (w_pair) begin
            o_push_data.valid[0] = 1'b1;
            o_push_data.tok[0]   = '{kind: pair_kind(r_pend), start: r_start,
                                     length: OFFSET_BITS'(2)};
        end else if (w_close && closes(r_mode)) begin
            o_push_data.valid[0] = 1'b1;
            o_push_data.tok[0]   = close_tok(r_mode, r_start, r_pos, r_pend, w_word_kind);
        end
        if (w_start && !is_space(w_c) && n_mode == M_IDLE) begin
            o_push_data.valid[1] = 1'b1;
            o_push_data.tok[1]   = '{kind: symbol_kind(w_c), start: r_pos,
                                     length: OFFSET_BITS'(1)};
        end
        if (i_in_data.final_byte) begin
            o_push_data.valid[2] = closes(n_mode);
            o_push_data.tok[2]   = close_tok(n_mode, n_start, w_pos_n, n_pend, w_word_kind);
            o_push_data.valid[3] = 1'b1;
            o_push_data.tok[3]   = '{kind: K_END, start: w_pos_n, length: '0};
        end
    end

    assign o_push = w_accept && (o_push_data.valid != '0);

    // advance lexer state; END returns all of it but the word buffer to the start of a source
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_pend  <= '0;
            r_count <= '0;
        end else if (w_accept) begin
            if (i_in_data.final_byte) begin
                r_mode  <= M_IDLE;
                r_pos   <= '0;
                r_start <= '0;
                r_pend  <= '0;
                r_count <= '0;
            end else begin
                r_mode  <= n_mode;
                r_pos   <= w_pos_n;
                r_start <= n_start;
                r_pend  <= n_pend;
                r_count <= n_count;
            end
        end
    end

    // word buffer holds payload only
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prefix <= n_prefix;
        end
    end

    `CHECK_NEXT(a_end_clears, w_accept && i_in_data.final_byte, r_mode == M_IDLE && r_pos == '0 && r_count == '0)

endmodule

/* hdl/stb_queue.sv */
`include "assert_macros.svh"

module stb_queue
    import stb_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_push_data,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_empty,
    output t_bundle o_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_bundle          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] wrap_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    // store bundles
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    // advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= wrap_inc(r_wr);
            if (i_pop)  r_rd <= wrap_inc(r_rd);
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

    `CHECK_SAME(a_no_overflow, r_count == CNT_W'(DEPTH), !i_push)
    `CHECK_SAME(a_no_underflow, i_pop, r_count != '0)
    `CHECK_NEXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

/* hdl/stb_back.sv */
module stb_back
    import stb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_bundle   i_head,
    input  logic      i_empty,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int SEL_W = $clog2(NUM_SLOTS);

    logic [NUM_SLOTS-1:0] r_taken;
    logic                 r_out_valid;
    t_out_item            r_out_data;

    logic [NUM_SLOTS-1:0] w_remain, w_bit, w_left;
    logic [SEL_W-1:0]     w_sel;
    logic                 w_load, w_last;

    // pick the earliest token of the head bundle not yet sent
    always_comb begin
        w_remain = i_head.valid & ~r_taken;
        w_sel    = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (w_remain[i]) w_sel = SEL_W'(i);
        end
        w_bit  = NUM_SLOTS'(1) << w_sel;
        w_left = w_remain & ~w_bit;
        w_last = (w_left == '0);
    end

    assign w_load = !i_empty && (!r_out_valid || i_out_ready);
    assign o_pop  = w_load && w_last;

    // output register: load a token, or drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_taken     <= '0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
            r_taken     <= w_last ? '0 : (r_taken | w_bit);
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data.token_kind  <= i_head.tok[w_sel].kind;
            r_out_data.text_start  <= i_head.tok[w_sel].start;
            r_out_data.text_length <= i_head.tok[w_sel].length;
            r_out_data.run_end     <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* hdl/source_byte_tokenizer.sv */
// Streaming source tokenizer: one source byte per input transaction, tokens out as
// kind, start offset and length, with run_end on the last token an input causes.
// The front lexer takes a byte every cycle while its bundle queue (QUEUE_DEPTH
// entries) has room; each byte yields zero to three tokens, which the output stage
// sends at one token per cycle while the output side is ready. Sustained rate is
// therefore one byte per cycle as long as the text averages at most one token per
// byte; a token passes the bundle queue and then the output register. Offsets are 16
// bits and saturate; END resets the lexer so the next byte starts a new source.
module source_byte_tokenizer
    import stb_pkg::*;
#(
    parameter int KEYWORD_CHARS = 11,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic    w_push, w_full, w_pop, w_empty;
    t_bundle w_push_data, w_head;

    stb_front #(
        .KEYWORD_CHARS(KEYWORD_CHARS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_push_data(w_push_data)
    );

    stb_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_data(w_push_data),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_empty    (w_empty),
        .o_head     (w_head)
    );

    stb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

endmodule

/* tb/sv/token_stream_checker.sv */
module token_stream_checker
    import stb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    input  logic      i_end_check,
    output int        o_fail_count,
    output int        o_tokens_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                     WORD_LIMIT = 11;
    localparam logic [OFFSET_BITS-1:0] OFFSET_TOP = '1;
    localparam logic [7:0]             CH_LF      = 8'h0A;
    localparam logic [7:0]             CH_QUOTE   = 8'h22;

    typedef enum logic [3:0] {
        LX_IDLE, LX_COMMENT, LX_SLASH, LX_ZERO, LX_DEC, LX_HEX, LX_BIN,
        LX_STRING, LX_WORD, LX_OP
    } t_lex_mode;

    string keyword_list [20] = '{
        "#define", "#include", "struct", "fn", "var", "const", "__interrupt",
        "__zeropage", "u8", "u16", "u32", "u64", "i8", "i16", "i32", "i64",
        "bool", "str", "true", "false"
    };
    string symbol_order = ":,;+-*/(){}[]=.<>!";

    // lexer state mirrored from the byte stream
    t_lex_mode              mode;
    logic [OFFSET_BITS-1:0] pos;
    logic [OFFSET_BITS-1:0] tok_start;
    logic [7:0]             word_buf [WORD_LIMIT];
    logic [3:0]             word_len;
    logic [7:0]             op_char;

    t_out_item item_tokens [$];
    t_out_item pending_tokens [$];
    int        fault_total = 0;

    function automatic logic [OFFSET_BITS-1:0] sat_next(logic [OFFSET_BITS-1:0] v);
        return (v == OFFSET_TOP) ? v : v + 1'b1;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_word_char(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || is_digit(c)
            || c == "_" || c == "#";
    endfunction

    function automatic logic [KIND_BITS-1:0] symbol_of(logic [7:0] c);
        for (int i = 0; i < symbol_order.len(); i++) begin
            if (symbol_order[i] == c) begin
                return K_SYM0 + KIND_BITS'(i);
            end
        end
        return K_UNKNOWN;
    endfunction

    // words longer than the keyword buffer are always identifiers
    function automatic logic [KIND_BITS-1:0] classify_word();
        logic hit;
        if (word_len > WORD_LIMIT) begin
            return K_IDENT;
        end
        for (int k = 0; k < 20; k++) begin
            if (keyword_list[k].len() == int'(word_len)) begin
                hit = 1'b1;
                for (int j = 0; j < keyword_list[k].len(); j++) begin
                    if (word_buf[j] != keyword_list[k][j]) begin
                        hit = 1'b0;
                    end
                end
                if (hit) begin
                    return K_KEYWORD0 + KIND_BITS'(k);
                end
            end
        end
        return K_IDENT;
    endfunction

    task automatic reset_lexer();
        mode      = LX_IDLE;
        pos       = '0;
        tok_start = '0;
        word_len  = '0;
        op_char   = '0;
        foreach (word_buf[i]) begin
            word_buf[i] = '0;
        end
    endtask

    task automatic emit_token(logic [KIND_BITS-1:0] kind, logic [OFFSET_BITS-1:0] start,
                              logic [OFFSET_BITS-1:0] len);
        t_out_item t;
        t.token_kind  = kind;
        t.text_start  = start;
        t.text_length = len;
        t.run_end     = 1'b0;
        item_tokens   = {item_tokens, t};
    endtask

    task automatic add_word_char(logic [7:0] c);
        if (word_len < WORD_LIMIT) begin
            word_buf[word_len] = c;
        end
        if (word_len <= WORD_LIMIT) begin
            word_len++;
        end
    endtask

    // close the open token whose text ends just before offset p
    task automatic close_open(logic [OFFSET_BITS-1:0] p);
        case (mode)
            LX_SLASH: emit_token(K_SLASH, tok_start, OFFSET_BITS'(1));
            LX_ZERO, LX_DEC, LX_HEX, LX_BIN: emit_token(K_NUMBER, tok_start, p - tok_start);
            LX_STRING: begin
                emit_token(K_STRING, sat_next(tok_start),
                           (p > tok_start) ? p - tok_start - 1'b1 : '0);
            end
            LX_WORD: emit_token(classify_word(), tok_start, p - tok_start);
            LX_OP: emit_token(symbol_of(op_char), tok_start, OFFSET_BITS'(1));
            default: ;
        endcase
        mode = LX_IDLE;
    endtask

    task automatic begin_token(logic [7:0] c, logic [OFFSET_BITS-1:0] p);
        tok_start = p;
        if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
            return;
        end else if (c == "/") begin
            mode = LX_SLASH;
        end else if (is_digit(c)) begin
            mode = (c == "0") ? LX_ZERO : LX_DEC;
        end else if (c == CH_QUOTE) begin
            mode = LX_STRING;
        end else if (is_word_char(c)) begin
            mode     = LX_WORD;
            word_len = '0;
            add_word_char(c);
        end else if (c == "=" || c == ">" || c == "<" || c == "!") begin
            mode    = LX_OP;
            op_char = c;
        end else begin
            emit_token(symbol_of(c), p, OFFSET_BITS'(1));
        end
    endtask

    task automatic consume(logic [7:0] c, logic [OFFSET_BITS-1:0] p);
        logic keep;
        keep = 1'b0;
        case (mode)
            LX_COMMENT: begin
                if (c == CH_LF) begin
                    mode = LX_IDLE;
                end
                return;
            end
            LX_SLASH: begin
                if (c == "/") begin
                    mode = LX_COMMENT;
                    return;
                end
            end
            LX_ZERO: begin
                if (c == "x") begin
                    mode = LX_HEX;
                    return;
                end
                if (c == "b") begin
                    mode = LX_BIN;
                    return;
                end
                if (is_digit(c)) begin
                    mode = LX_DEC;
                    return;
                end
            end
            LX_DEC: keep = is_digit(c);
            LX_HEX: keep = is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
            LX_BIN: keep = (c == "0" || c == "1");
            LX_STRING: begin
                if (c == CH_QUOTE) begin
                    close_open(p);
                end
                return;
            end
            LX_WORD: begin
                if (is_word_char(c)) begin
                    add_word_char(c);
                    return;
                end
            end
            LX_OP: begin
                if (c == "=") begin
                    case (op_char)
                        "=": emit_token(K_EQ_EQ, tok_start, OFFSET_BITS'(2));
                        ">": emit_token(K_GE, tok_start, OFFSET_BITS'(2));
                        "<": emit_token(K_LE, tok_start, OFFSET_BITS'(2));
                        default: emit_token(K_NE, tok_start, OFFSET_BITS'(2));
                    endcase
                    mode = LX_IDLE;
                    return;
                end
            end
            default: ;
        endcase
        if (keep) begin
            return;
        end
        close_open(p);
        begin_token(c, p);
    endtask

    // predict every token one source transaction causes
    task automatic tokenize_item(t_in_item it);
        item_tokens.delete();
        if (!it.flush_only) begin
            consume(it.source_byte, pos);
            pos = sat_next(pos);
        end
        if (it.final_byte) begin
            close_open(pos);
            emit_token(K_END, pos, '0);
            reset_lexer();
        end
        if (item_tokens.size() > 0) begin
            item_tokens[item_tokens.size()-1].run_end = 1'b1;
        end
        pending_tokens = {pending_tokens, item_tokens};
    endtask

    // predict on input transactions, compare on output transactions
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            reset_lexer();
            pending_tokens.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                tokenize_item(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_tokens.size() == 0) begin
                    $error("token transaction with none predicted: kind %0d start %0d len %0d",
                           i_out_data.token_kind, i_out_data.text_start,
                           i_out_data.text_length);
                    fault_total++;
                end else begin
                    want = pending_tokens.pop_front();
                    if (i_out_data.token_kind != want.token_kind) begin
                        $error("token_kind: expected %0d, actual %0d",
                               want.token_kind, i_out_data.token_kind);
                        fault_total++;
                    end
                    if (i_out_data.text_start != want.text_start) begin
                        $error("text_start: expected %0d, actual %0d",
                               want.text_start, i_out_data.text_start);
                        fault_total++;
                    end
                    if (i_out_data.text_length != want.text_length) begin
                        $error("text_length: expected %0d, actual %0d",
                               want.text_length, i_out_data.text_length);
                        fault_total++;
                    end
                    if (i_out_data.run_end != want.run_end) begin
                        $error("run_end: expected %0d, actual %0d",
                               want.run_end, i_out_data.run_end);
                        fault_total++;
                    end
                end
            end
            // count tokens that never came out
            if (i_end_check && pending_tokens.size() != 0) begin
                $error("%0d predicted tokens never arrived", pending_tokens.size());
                fault_total += pending_tokens.size();
                pending_tokens.delete();
            end
        end
        o_fail_count <= fault_total;
        o_tokens_due <= pending_tokens.size();
    end

endmodule

/* tb/sv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import stb_pkg::*;

    localparam int         CYCLE_LIMIT  = 500_000;
    localparam int         RANDOM_ITEMS = 300;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_QUOTE     = 8'h22;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;
    logic      end_check = 1'b0;
    int        fail_count;
    int        tokens_due;
    int        cycle_count = 0;
    logic      calm = 1'b0;

    logic [7:0] lexeme_bytes [$];
    string      pair_heads = "=><!";

    source_byte_tokenizer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    token_stream_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_end_check  (end_check),
        .o_fail_count (fail_count),
        .o_tokens_due (tokens_due)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // abort a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // hold off the token side for a random number of cycles per transaction
    initial begin
        int wait_cycles;
        forever begin
            wait_cycles = calm ? 0 : $urandom_range(0, 3);
            if (wait_cycles > 0) begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // send one source transaction after a random gap, hold it until taken
    task automatic feed_source(logic [7:0] b, logic fin, logic fl);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{source_byte: b, final_byte: fin, flush_only: fl};
        do @(posedge clk); while (!in_ready);
    endtask

    // append one byte to the lexeme under construction
    function automatic void add_byte(logic [7:0] b);
        lexeme_bytes = {lexeme_bytes, b};
    endfunction

    function automatic logic [7:0] word_char(logic lead);
        int r;
        r = $urandom_range(0, lead ? 53 : 63);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r == 52) return "_";
        if (r == 53) return "#";
        return 8'("0" + r - 54);
    endfunction

    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 0) ? 8'h20 : 8'(8 + r);
    endfunction

    // build one lexeme with random content, sometimes followed by a blank
    task automatic compose_lexeme();
        int         k;
        int         n;
        logic [7:0] c;
        lexeme_bytes.delete();
        case ($urandom_range(0, 12))
            0: begin
                k = $urandom_range(0, KW_COUNT-1);
                for (int j = 0; j < int'(KW_LEN[k]); j++) add_byte(kw_char(k, j));
            end
            1: begin
                // near miss of a keyword
                k = $urandom_range(0, KW_COUNT-1);
                n = int'(KW_LEN[k]);
                for (int j = 0; j < n; j++) add_byte(kw_char(k, j));
                case ($urandom_range(0, 2))
                    0: add_byte(word_char(1'b0));
                    1: lexeme_bytes[$urandom_range(1, n-1)] = word_char(1'b0);
                    default: void'(lexeme_bytes.pop_back());
                endcase
            end
            2: begin
                n = $urandom_range(1, 14);
                add_byte(word_char(1'b1));
                for (int j = 1; j < n; j++) add_byte(word_char(1'b0));
            end
            3: begin
                add_byte(($urandom_range(0, 3) == 0) ? 8'("0")
                         : 8'("0" + $urandom_range(1, 9)));
                n = $urandom_range(0, 5);
                for (int j = 0; j < n; j++) add_byte(8'("0" + $urandom_range(0, 9)));
            end
            4: begin
                add_byte("0");
                add_byte("x");
                n = $urandom_range(0, 5);
                for (int j = 0; j < n; j++) begin
                    k = $urandom_range(0, 21);
                    add_byte((k < 10) ? 8'("0" + k) :
                             (k < 16) ? 8'("a" + k - 10) : 8'("A" + k - 16));
                end
            end
            5: begin
                add_byte("0");
                add_byte("b");
                n = $urandom_range(0, 6);
                for (int j = 0; j < n; j++) add_byte(8'("0" + $urandom_range(0, 1)));
            end
            6: begin
                add_byte(CH_QUOTE);
                n = $urandom_range(0, 6);
                for (int j = 0; j < n; j++) begin
                    do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
                    add_byte(c);
                end
                if ($urandom_range(0, 9) != 0) add_byte(CH_QUOTE);
            end
            7: begin
                add_byte("/");
                add_byte("/");
                n = $urandom_range(0, 8);
                for (int j = 0; j < n; j++) begin
                    do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
                    add_byte(c);
                end
                add_byte(CH_LF);
            end
            8: begin
                add_byte(pair_heads[$urandom_range(0, 3)]);
                add_byte("=");
            end
            9: begin
                // operator head not followed by an equals sign
                add_byte(pair_heads[$urandom_range(0, 3)]);
                do c = 8'($urandom_range(0, 255)); while (c == "=");
                add_byte(c);
            end
            10: add_byte(SYM_CHARS[$urandom_range(0, SYM_COUNT-1)]);
            11: begin
                n = $urandom_range(1, 3);
                for (int j = 0; j < n; j++) add_byte(blank_char());
            end
            default: begin
                n = $urandom_range(1, 3);
                for (int j = 0; j < n; j++) add_byte(8'($urandom_range(0, 255)));
            end
        endcase
        if ($urandom_range(0, 1) == 1) add_byte(blank_char());
    endtask

    initial begin
        string opening;
        int    random_items;
        logic  end_source;
        logic  by_flush;

        opening      = "0x/ 0b1//z\n!=<.";
        random_items = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: a hex prefix without digits, lone slash, comment, operators,
        // byte extremes, unterminated string, flush with and without end
        for (int i = 0; i < opening.len(); i++) feed_source(opening[i], 1'b0, 1'b0);
        feed_source(8'h00, 1'b0, 1'b0);
        feed_source(8'hFF, 1'b0, 1'b0);
        feed_source(CH_QUOTE, 1'b0, 1'b0);
        feed_source("a", 1'b0, 1'b0);
        feed_source("b", 1'b0, 1'b0);
        feed_source(8'hA5, 1'b0, 1'b1);
        feed_source(8'h5A, 1'b1, 1'b1);
        feed_source("7", 1'b1, 1'b0);

        // random well-formed lexemes with noise, sources ended now and then
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) calm = !calm;
            compose_lexeme();
            end_source = ($urandom_range(0, 11) == 0);
            by_flush   = 1'($urandom_range(0, 1));
            foreach (lexeme_bytes[i]) begin
                feed_source(lexeme_bytes[i],
                            end_source && !by_flush && i == lexeme_bytes.size() - 1, 1'b0);
                random_items++;
            end
            if (end_source && by_flush) begin
                feed_source(8'($urandom_range(0, 255)), 1'b1, 1'b1);
                random_items++;
            end
            if ($urandom_range(0, 19) == 0) feed_source(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
        in_valid <= 1'b0;

        // drain, let the pipeline settle, then sweep for leftovers
        do @(posedge clk); while (tokens_due != 0);
        repeat (8) @(posedge clk);
        end_check <= 1'b1;
        @(posedge clk);
        end_check <= 1'b0;
        @(posedge clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
